FILE: hw/rtl/phase_binned_waveform_learner_top_macros.svh
// ----------------------------------------------------------------------------
// Phase-binned waveform learner assertion macros
// Shared macros for the concurrent checks of the learner.
// ----------------------------------------------------------------------------
`ifndef PHASE_BINNED_WAVEFORM_LEARNER_TOP_MACROS_SVH
`define PHASE_BINNED_WAVEFORM_LEARNER_TOP_MACROS_SVH

// Check that is switched off while reset is high.
`define PBWL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also holds across reset.
`define PBWL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/pbwl_pkg.sv
// ----------------------------------------------------------------------------
// Phase-binned waveform learner package
// Shared sizes, codes, constants and types of the learner.
// ----------------------------------------------------------------------------
package pbwl_pkg;

   localparam int BINS   = 64;
   localparam int ADDR_W = $clog2(BINS);

   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_LEARNING = 2'd1;
   localparam logic [1:0] MODE_DONE     = 2'd2;
   localparam logic [1:0] MODE_FINISHED = 2'd3;

   localparam logic [1:0] REG_START_CYCLE  = 2'd0;
   localparam logic [1:0] REG_LEARN_CYCLES = 2'd1;
   localparam logic [1:0] REG_SLOPE_SCALE  = 2'd2;

   localparam logic [15:0] SLOPE_SCALE_RESET = 16'd256;

   // Division by ten as a multiplication by ceil(2^23 / 10), exact below 2^22.
   localparam int          RECIP_SHIFT = 23;
   localparam logic [19:0] RECIP       = 20'd838861;
   // Offset of 32768 * 10 makes the blend sum positive before the division.
   localparam logic signed [21:0] BLEND_BIAS = 22'sd327680;

   typedef struct packed {
      logic               unwritten;
      logic signed [15:0] wave;
      logic signed [31:0] slope;
   } entry_type;

   typedef struct packed {
      logic blend_en;
      logic diff_en;
      logic mult_en;
   } calc_ctrl_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        was_learning;
      logic [15:0] slope_scale;
   } mode_status_type;

endpackage

FILE: hw/rtl/pbwl_mem.sv
// ----------------------------------------------------------------------------
// Bin table memory
// One write port and two registered read ports over the bin entries.
// ----------------------------------------------------------------------------
module pbwl_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [pbwl_pkg::ADDR_W-1:0] wr_addr,
   input  pbwl_pkg::entry_type       wr_data,
   input  logic                      rd_en,
   input  logic [pbwl_pkg::ADDR_W-1:0] rd_addr_a,
   input  logic [pbwl_pkg::ADDR_W-1:0] rd_addr_b,
   output pbwl_pkg::entry_type       rd_data_a,
   output pbwl_pkg::entry_type       rd_data_b
);
   import pbwl_pkg::*;

   entry_type mem [BINS];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hw/rtl/pbwl_mode.sv
// ----------------------------------------------------------------------------
// Mode and configuration registers
// Holds the configuration and steps the four-state learning mode per item.
// ----------------------------------------------------------------------------
module pbwl_mode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   input  logic                      accept,
   input  logic [15:0]               tick_cycle,
   output pbwl_pkg::mode_status_type status
);
   import pbwl_pkg::*;

   logic [15:0] start_ff;
   logic [15:0] learn_ff;
   logic [15:0] scale_ff;
   logic [1:0]  mode_ff;
   logic [1:0]  mode_in;
   logic        was_learning_ff;
   logic [16:0] window_end;

   assign window_end = {1'b0, start_ff} + {1'b0, learn_ff};

   always_comb begin
      mode_in = mode_ff;
      if (tick_cycle < start_ff) begin
         mode_in = MODE_IDLE;
      end else if (mode_ff == MODE_IDLE && {1'b0, tick_cycle} < window_end) begin
         mode_in = MODE_LEARNING;
      end else if (mode_ff == MODE_LEARNING && {1'b0, tick_cycle} >= window_end) begin
         mode_in = MODE_DONE;
      end
      if (mode_ff == MODE_DONE) begin
         mode_in = MODE_FINISHED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff        <= 16'd0;
         learn_ff        <= 16'd0;
         scale_ff        <= SLOPE_SCALE_RESET;
         mode_ff         <= MODE_IDLE;
         was_learning_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START_CYCLE:  start_ff <= csr_wdata;
               REG_LEARN_CYCLES: learn_ff <= csr_wdata;
               REG_SLOPE_SCALE:  scale_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            mode_ff         <= mode_in;
            was_learning_ff <= (mode_ff == MODE_LEARNING);
         end
      end
   end

   assign status.mode         = mode_ff;
   assign status.was_learning = was_learning_ff;
   assign status.slope_scale  = scale_ff;

endmodule

FILE: hw/rtl/pbwl_calc.sv
// ----------------------------------------------------------------------------
// Bin update datapath
// Blends the stored value with the sample and forms the saturated slope.
// ----------------------------------------------------------------------------
module pbwl_calc (
   input  logic                      clock,
   input  pbwl_pkg::calc_ctrl_type   ctrl,
   input  pbwl_pkg::entry_type       cur_entry,
   input  pbwl_pkg::entry_type       prev_entry,
   input  logic signed [15:0]        sample,
   input  logic [15:0]               slope_scale,
   output logic signed [15:0]        new_wave,
   output logic signed [31:0]        new_slope
);
   import pbwl_pkg::*;

   logic signed [21:0] acc;
   logic [39:0]        prod_ff;
   logic               fresh_ff;
   logic [15:0]        quot;
   logic signed [15:0] blend;
   logic signed [15:0] wave_ff;
   logic signed [16:0] diff_ff;
   logic signed [33:0] mult_ff;

   assign acc = $signed({{6{cur_entry.wave[15]}}, cur_entry.wave}) * 22'sd9
              + $signed({{6{sample[15]}}, sample}) + 22'sd5 + BLEND_BIAS;

   assign quot  = prod_ff[RECIP_SHIFT +: 16];
   assign blend = fresh_ff ? sample : $signed({~quot[15], quot[14:0]});

   always_ff @(posedge clock) begin
      if (ctrl.blend_en) begin
         prod_ff  <= {20'd0, acc[19:0]} * {20'd0, RECIP};
         fresh_ff <= cur_entry.unwritten;
      end
      if (ctrl.diff_en) begin
         wave_ff <= blend;
         diff_ff <= $signed({blend[15], blend}) - $signed({prev_entry.wave[15], prev_entry.wave});
      end
      if (ctrl.mult_en) begin
         mult_ff <= $signed({{17{diff_ff[16]}}, diff_ff}) * $signed({18'd0, slope_scale});
      end
   end

   always_comb begin
      if (mult_ff[33:31] == 3'b000 || mult_ff[33:31] == 3'b111) begin
         new_slope = mult_ff[31:0];
      end else if (mult_ff[33]) begin
         new_slope = 32'sh8000_0000;
      end else begin
         new_slope = 32'sh7FFF_FFFF;
      end
   end

   assign new_wave = wave_ff;

endmodule

FILE: hw/rtl/phase_binned_waveform_learner_top.sv
// ----------------------------------------------------------------------------
// Phase-binned waveform learner
// Learns a waveform per phase bin during a cycle window and reports slopes.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  cycle_count, phase, sensor_sample
//   rsp      out        rsp_valid/rsp_ready  mode, bin_index, bin_value, bin_slope
//   csr      in         csr_we               csr_index, csr_wdata
//
// An item is taken only when the block is free; the bin entries sit in one
// memory read at the bin and its neighbor in the cycle after acceptance.
// The result is offered after the read outside learning, and after the
// read, blend, difference, multiply and write steps while learning.
// After reset a clearing pass over all BINS (64) entries runs before items are taken.
// A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
`include "phase_binned_waveform_learner_top_macros.svh"

module phase_binned_waveform_learner_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_cycle_count,
   input  logic [15:0]        req_phase,
   input  logic signed [15:0] req_sensor_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_mode,
   output logic [5:0]         rsp_bin_index,
   output logic signed [15:0] rsp_bin_value,
   output logic signed [31:0] rsp_bin_slope,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import pbwl_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DIFF  = 3'd3;
   localparam logic [2:0] S_MULT  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [ADDR_W-1:0]  clr_ff;
   logic [ADDR_W-1:0]  idx_ff;
   logic signed [15:0] sample_ff;
   logic signed [15:0] value_ff;
   logic signed [31:0] slope_ff;
   logic               accept;
   logic [31:0]        phase_prod;
   logic [ADDR_W-1:0]  idx;
   logic [ADDR_W-1:0]  prev_idx;
   logic [ADDR_W+5:0]  idx_ext;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_data;
   entry_type          cur_entry;
   entry_type          prev_entry;
   calc_ctrl_type      ctrl;
   mode_status_type    status;
   logic signed [15:0] new_wave;
   logic signed [31:0] new_slope;
   logic               done_accept;
   logic               resp_src;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign accept    = req_valid && req_ready;

   assign phase_prod = {16'd0, req_phase} * 32'(BINS);
   assign idx        = phase_prod[16 +: ADDR_W];
   assign prev_idx   = (idx == '0) ? ADDR_W'(BINS - 1) : idx - 1'b1;

   assign ctrl.blend_en = (state_ff == S_READ);
   assign ctrl.diff_en  = (state_ff == S_DIFF);
   assign ctrl.mult_en  = (state_ff == S_MULT);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data.unwritten = 1'b0;
      wr_data.wave      = new_wave;
      wr_data.slope     = new_slope;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data.unwritten = 1'b1;
         wr_data.wave      = 16'sd0;
         wr_data.slope     = 32'sd0;
      end else if (state_ff == S_WRITE) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == ADDR_W'(BINS - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = S_READ;
         S_READ:  state_in = status.was_learning ? S_DIFF : S_RESP;
         S_DIFF:  state_in = S_MULT;
         S_MULT:  state_in = S_WRITE;
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= idx;
         sample_ff <= req_sensor_sample;
      end
      if (state_ff == S_READ && !status.was_learning) begin
         value_ff <= cur_entry.wave;
         slope_ff <= cur_entry.slope;
      end
      if (state_ff == S_WRITE) begin
         value_ff <= new_wave;
         slope_ff <= new_slope;
      end
   end

   pbwl_mem u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (idx),
      .rd_addr_b (prev_idx),
      .rd_data_a (cur_entry),
      .rd_data_b (prev_entry)
   );

   pbwl_mode u_mode (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .tick_cycle  (req_cycle_count),
      .status      (status)
   );

   pbwl_calc u_calc (
      .clock       (clock),
      .ctrl        (ctrl),
      .cur_entry   (cur_entry),
      .prev_entry  (prev_entry),
      .sample      (sample_ff),
      .slope_scale (status.slope_scale),
      .new_wave    (new_wave),
      .new_slope   (new_slope)
   );

   assign idx_ext       = (ADDR_W + 6)'(idx_ff);
   assign rsp_mode      = status.mode;
   assign rsp_bin_index = idx_ext[5:0];
   assign rsp_bin_value = value_ff;
   assign rsp_bin_slope = slope_ff;

   assign done_accept = accept && (status.mode == MODE_DONE);
   assign resp_src    = (state_ff == S_READ) || (state_ff == S_WRITE);

   `PBWL_ASSERT_ALWAYS(a_reset_clears, reset |=> state_ff == S_CLEAR, "no clearing pass")
   `PBWL_ASSERT(a_one_item, !(req_ready && rsp_valid), "item taken while a result waits")
   `PBWL_ASSERT(a_done_next, done_accept |=> status.mode == MODE_FINISHED, "no finished mode")
   `PBWL_ASSERT(a_resp_source, $rose(rsp_valid) |-> $past(resp_src), "result not from work")

endmodule
